// ----- rtl/rls_pkg.sv -----
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types, codes and helpers for the resolution level selector.
// ----------------------------------------------------------------------------
`default_nettype none

package rls_pkg;

    localparam int DIM_W  = 32;
    localparam int AREA_W = 2 * DIM_W;
    localparam int LVL_W  = 6;
    localparam int MODE_W = 2;
    localparam int ADDR_W = 2;

    localparam int MAX_LEVELS_DEF = 32;

    localparam logic [MODE_W-1:0] MODE_CLOSEST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UP      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN    = 2'd2;

    localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [ADDR_W-1:0] REG_LEVEL_COUNT  = 2'd2;

    // one query as it travels along the chain
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DIM_W-1:0]  req_width;
        logic [DIM_W-1:0]  req_height;
        logic [AREA_W-1:0] req_area;
        logic [AREA_W-1:0] diff;      // area difference at the receiving cell's level
        logic [AREA_W-1:0] best;
        logic [LVL_W-1:0]  best_k;
        logic              found;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } item_t;

    function automatic logic [AREA_W-1:0] abs_diff(input logic [AREA_W-1:0] a,
                                                   input logic [AREA_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rls_cell.sv -----
// ----------------------------------------------------------------------------
// rls_cell
// One decomposition level: derives its size and area, updates the running
// choice of the passing transaction and forwards it.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_cell #(
    parameter int K = 0
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [rls_pkg::DIM_W-1:0]        image_width,
    input  wire logic [rls_pkg::DIM_W-1:0]        image_height,
    input  wire logic [rls_pkg::LVL_W-1:0]        lvl,
    input  wire logic [rls_pkg::AREA_W-1:0]       next_area,
    output logic      [rls_pkg::AREA_W-1:0]       area,
    input  wire logic                             in_vld,
    input  wire rls_pkg::item_t                   in_item,
    output logic                                  out_vld,
    output rls_pkg::item_t                        out_item
);

    localparam logic [rls_pkg::DIM_W:0]   ROUND = (33'd1 << K) - 33'd1;
    localparam logic [rls_pkg::LVL_W-1:0] KIDX  = rls_pkg::LVL_W'(K);

    logic [rls_pkg::DIM_W:0]    w_sum;
    logic [rls_pkg::DIM_W:0]    h_sum;
    logic [rls_pkg::DIM_W-1:0]  w;
    logic [rls_pkg::DIM_W-1:0]  h;
    logic [rls_pkg::AREA_W-1:0] area_reg;
    logic [rls_pkg::AREA_W-1:0] area_next;
    logic                       vld_reg;
    rls_pkg::item_t             item_reg;
    rls_pkg::item_t             item_next;
    logic                       active;
    logic                       covers;
    logic                       fits;
    logic                       take;

    assign w_sum     = {1'b0, image_width} + ROUND;
    assign h_sum     = {1'b0, image_height} + ROUND;
    assign w         = rls_pkg::DIM_W'(w_sum >> K);
    assign h         = rls_pkg::DIM_W'(h_sum >> K);
    assign area_next = rls_pkg::AREA_W'(w) * rls_pkg::AREA_W'(h);

    assign active = (KIDX <= lvl);
    assign covers = (w >= in_item.req_width) && (h >= in_item.req_height);
    assign fits   = (w <= in_item.req_width) && (h <= in_item.req_height);

    always_comb
    begin
        case (in_item.mode)
            rls_pkg::MODE_UP:
            begin
                take = (K == 0) || (active && covers);
            end
            rls_pkg::MODE_DOWN:
            begin
                take = active && !in_item.found && (fits || (KIDX == lvl));
            end
            default:
            begin
                take = (K == 0) || (active && (in_item.diff < in_item.best));
            end
        endcase
    end

    always_comb
    begin
        item_next      = in_item;
        item_next.diff = rls_pkg::abs_diff(next_area, in_item.req_area);
        if (take)
        begin
            item_next.best   = in_item.diff;
            item_next.best_k = KIDX;
            item_next.found  = 1'b1;
            item_next.width  = w;
            item_next.height = h;
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
        item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    assign area     = area_reg;
    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

`default_nettype wire

// ----- rtl/resolution_level_select.sv -----
// ----------------------------------------------------------------------------
// resolution_level_select
// Picks a wavelet resolution of the configured image for a requested size,
// closest area, round up or round down, through a chain of level cells.
// ----------------------------------------------------------------------------
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------
// query     | mode, req_width, req_height               | start && !busy
// result    | resolution, out_width, out_height         | done, one cycle
// config    | cfg_addr, cfg_wdata                       | cfg_we
//
// One query per cycle; each result passes through the input, request-area
// and first-difference stages, one stage per level cell and the output
// register. busy stays low. Reset clears the pipeline valid bits and loads
// width 1, height 1, level count 0. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module resolution_level_select #(
    parameter int MAX_LEVELS = rls_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rls_pkg::ADDR_W-1:0]    cfg_addr,
    input  wire logic [rls_pkg::DIM_W-1:0]     cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rls_pkg::MODE_W-1:0]    mode,
    input  wire logic [rls_pkg::DIM_W-1:0]     req_width,
    input  wire logic [rls_pkg::DIM_W-1:0]     req_height,
    output logic                               done,
    output logic      [rls_pkg::LVL_W-1:0]     resolution,
    output logic      [rls_pkg::DIM_W-1:0]     out_width,
    output logic      [rls_pkg::DIM_W-1:0]     out_height
);

    localparam int LATENCY = MAX_LEVELS + 5;
    localparam logic [rls_pkg::LVL_W-1:0] MAX_LVL = rls_pkg::LVL_W'(MAX_LEVELS);

    logic [rls_pkg::DIM_W-1:0]  image_width_reg;
    logic [rls_pkg::DIM_W-1:0]  image_height_reg;
    logic [rls_pkg::LVL_W-1:0]  level_count_reg;
    logic [rls_pkg::LVL_W-1:0]  lvl;

    logic                       s0_vld_reg;
    logic                       s1_vld_reg;
    logic                       s2_vld_reg;
    rls_pkg::item_t             s0_reg;
    rls_pkg::item_t             s1_reg;
    rls_pkg::item_t             s2_reg;
    rls_pkg::item_t             s0_next;
    rls_pkg::item_t             s1_next;
    rls_pkg::item_t             s2_next;

    logic                       cell_vld  [0:MAX_LEVELS+1];
    rls_pkg::item_t             cell_item [0:MAX_LEVELS+1];
    logic [rls_pkg::AREA_W-1:0] cell_area [0:MAX_LEVELS+1];

    logic                       done_reg;
    logic [rls_pkg::LVL_W-1:0]  resolution_reg;
    logic [rls_pkg::DIM_W-1:0]  out_width_reg;
    logic [rls_pkg::DIM_W-1:0]  out_height_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= rls_pkg::DIM_W'(1);
            image_height_reg <= rls_pkg::DIM_W'(1);
            level_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                rls_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                rls_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                rls_pkg::REG_LEVEL_COUNT:  level_count_reg  <= cfg_wdata[rls_pkg::LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign lvl  = (level_count_reg > MAX_LVL) ? MAX_LVL : level_count_reg;
    assign busy = 1'b0;

    // front stages: capture, request area, difference at level 0
    always_comb
    begin
        s0_next            = '0;
        s0_next.mode       = mode;
        s0_next.req_width  = req_width;
        s0_next.req_height = req_height;

        s1_next            = s0_reg;
        s1_next.req_area   = rls_pkg::AREA_W'(s0_reg.req_width) *
                             rls_pkg::AREA_W'(s0_reg.req_height);

        s2_next            = s1_reg;
        s2_next.diff       = rls_pkg::abs_diff(cell_area[0], s1_reg.req_area);
        s2_next.found      = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start && !busy;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    assign cell_vld[0]             = s2_vld_reg;
    assign cell_item[0]            = s2_reg;
    assign cell_area[MAX_LEVELS+1] = '0;

    for (genvar k = 0; k <= MAX_LEVELS; k++)
    begin : g_cell
        rls_cell #(
            .K(k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .image_width (image_width_reg),
            .image_height(image_height_reg),
            .lvl         (lvl),
            .next_area   (cell_area[k+1]),
            .area        (cell_area[k]),
            .in_vld      (cell_vld[k]),
            .in_item     (cell_item[k]),
            .out_vld     (cell_vld[k+1]),
            .out_item    (cell_item[k+1])
        );
    end

    // output register
    always_ff @(posedge clk)
    begin
        resolution_reg <= lvl - cell_item[MAX_LEVELS+1].best_k;
        out_width_reg  <= cell_item[MAX_LEVELS+1].width;
        out_height_reg <= cell_item[MAX_LEVELS+1].height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cell_vld[MAX_LEVELS+1];
        end
    end

    assign done       = done_reg;
    assign resolution = resolution_reg;
    assign out_width  = out_width_reg;
    assign out_height = out_height_reg;

    // checks
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transaction result missing at fixed latency");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

    a_res_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (resolution <= lvl))
        else $error("resolution beyond level count");

    a_width_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((out_width != '0) || (image_width_reg == '0)))
        else $error("zero width from a non-zero image");

endmodule

`default_nettype wire
